// ===== src/rgb_command_frame_parser_core_defines.svh =====
// Assertion macros for the RGB command frame parser checker.
// No dependencies; taken in by the checker file only.
`ifndef RGB_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH
`define RGB_COMMAND_FRAME_PARSER_CORE_DEFINES_SVH

// Checked only outside reset.
`define RGBCFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define RGBCFP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// ===== src/rgbcfp_pkg.sv =====
// Package for the RGB command frame parser: widths, characters, register indexes,
// parse phase codes and the percent-to-duty scaling. No dependencies.
package rgbcfp_pkg;

    localparam int BYTE_W    = 8;
    localparam int PCT_W     = 7;
    localparam int DUTY_W    = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR        = 2'd2;

    localparam logic [BYTE_W-1:0] RST_MAX_BODY_LENGTH = 8'd20;
    localparam logic [BYTE_W-1:0] RST_START_CHAR      = 8'h3F;  // '?'
    localparam logic [BYTE_W-1:0] RST_END_CHAR        = 8'h3B;  // ';'

    localparam logic [BYTE_W-1:0] CHAR_R  = 8'h72;
    localparam logic [BYTE_W-1:0] CHAR_G  = 8'h67;
    localparam logic [BYTE_W-1:0] CHAR_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CHAR_EQ = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;

    localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

    // 255/100 as a fraction over 2^22; exact floor for every percent up to 100
    localparam int               DUTY_SHIFT = 22;
    localparam int               RECIP_W    = 24;
    localparam int               PROD_W     = PCT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] DUTY_RECIP = 24'd10695720;

    typedef enum logic [9:0] {
        PH_R     = 10'b00_0000_0001,
        PH_R_EQ  = 10'b00_0000_0010,
        PH_R_DIG = 10'b00_0000_0100,
        PH_G     = 10'b00_0000_1000,
        PH_G_EQ  = 10'b00_0001_0000,
        PH_G_DIG = 10'b00_0010_0000,
        PH_B     = 10'b00_0100_0000,
        PH_B_EQ  = 10'b00_1000_0000,
        PH_B_DIG = 10'b01_0000_0000,
        PH_TRAIL = 10'b10_0000_0000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] max_body_length;
        logic [BYTE_W-1:0] start_char;
        logic [BYTE_W-1:0] end_char;
    } cfg_t;

    typedef struct packed {
        logic              hit;
        logic [DUTY_W-1:0] red_duty;
        logic [DUTY_W-1:0] green_duty;
        logic [DUTY_W-1:0] blue_duty;
    } result_t;

    function automatic logic [DUTY_W-1:0] duty_of(input logic [PCT_W-1:0] pct);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(pct) * PROD_W'(DUTY_RECIP);
        return prod[DUTY_SHIFT +: DUTY_W];
    endfunction

endpackage

// ===== src/rgbcfp_if.sv =====
// Channel interfaces of the RGB command frame parser: received bytes,
// duty results and configuration writes. Depends on rgbcfp_pkg.
interface rgbcfp_byte_if;
    import rgbcfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rgbcfp_duty_if;
    import rgbcfp_pkg::*;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;

    modport source (output valid, output red_duty, output green_duty, output blue_duty,
                    input ready);
    modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                    output ready);
endinterface

interface rgbcfp_cfg_if;
    import rgbcfp_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/rgbcfp_parser.sv =====
// Frame parse state and per-byte update for the RGB command frame parser.
// Depends on rgbcfp_pkg.
module rgbcfp_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [rgbcfp_pkg::BYTE_W-1:0] rx_byte,
    input  rgbcfp_pkg::cfg_t              cfg,
    output rgbcfp_pkg::result_t           res
);
    import rgbcfp_pkg::*;

    logic              hunting_reg, hunting_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    phase_t            phase_reg, phase_next;
    logic              bad_reg, bad_next;
    logic [PCT_W-1:0]  red_reg, red_next;
    logic [PCT_W-1:0]  green_reg, green_next;
    logic [PCT_W-1:0]  blue_reg, blue_next;

    logic              is_digit;
    logic [3:0]        digit;
    logic              hit;

    function automatic logic [PCT_W-1:0] add_digit(input logic [PCT_W-1:0] p,
                                                    input logic [3:0] d);
        logic [9:0] v;
        v = 10'(p) * 10'd10 + 10'(d);
        return (v > 10'(PCT_MAX)) ? PCT_MAX : v[PCT_W-1:0];
    endfunction

    assign is_digit = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    assign digit    = 4'(rx_byte - CHAR_0);

    always_comb
    begin
        hunting_next = hunting_reg;
        count_next   = count_reg;
        phase_next   = phase_reg;
        bad_next     = bad_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        hit          = 1'b0;

        if (hunting_reg)
        begin
            if (rx_byte == cfg.start_char)
            begin
                hunting_next = 1'b0;
                count_next   = '0;
                phase_next   = PH_R;
                bad_next     = 1'b0;
                red_next     = '0;
                green_next   = '0;
                blue_next    = '0;
            end
        end
        else if (rx_byte == cfg.end_char)
        begin
            hunting_next = 1'b1;
            hit = !bad_reg && ((phase_reg == PH_B_DIG) || (phase_reg == PH_TRAIL));
        end
        else if (count_reg >= cfg.max_body_length)
        begin
            // over length: drop silently
            hunting_next = 1'b1;
        end
        else
        begin
            count_next = count_reg + 8'd1;
            unique case (phase_reg)
                PH_R:
                begin
                    bad_next   = bad_reg || (rx_byte != CHAR_R);
                    phase_next = PH_R_EQ;
                end
                PH_R_EQ:
                begin
                    bad_next   = bad_reg || (rx_byte != CHAR_EQ);
                    phase_next = PH_R_DIG;
                end
                PH_R_DIG:
                begin
                    if (is_digit)
                        red_next = add_digit(red_reg, digit);
                    else
                        phase_next = PH_G;  // separator eaten unchecked
                end
                PH_G:
                begin
                    bad_next   = bad_reg || (rx_byte != CHAR_G);
                    phase_next = PH_G_EQ;
                end
                PH_G_EQ:
                begin
                    bad_next   = bad_reg || (rx_byte != CHAR_EQ);
                    phase_next = PH_G_DIG;
                end
                PH_G_DIG:
                begin
                    if (is_digit)
                        green_next = add_digit(green_reg, digit);
                    else
                        phase_next = PH_B;
                end
                PH_B:
                begin
                    bad_next   = bad_reg || (rx_byte != CHAR_B);
                    phase_next = PH_B_EQ;
                end
                PH_B_EQ:
                begin
                    bad_next   = bad_reg || (rx_byte != CHAR_EQ);
                    phase_next = PH_B_DIG;
                end
                PH_B_DIG:
                begin
                    if (is_digit)
                        blue_next = add_digit(blue_reg, digit);
                    else
                        phase_next = PH_TRAIL;
                end
                default:
                    phase_next = PH_TRAIL;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            count_reg   <= '0;
            phase_reg   <= PH_R;
            bad_reg     <= 1'b0;
            red_reg     <= '0;
            green_reg   <= '0;
            blue_reg    <= '0;
        end
        else if (step)
        begin
            hunting_reg <= hunting_next;
            count_reg   <= count_next;
            phase_reg   <= phase_next;
            bad_reg     <= bad_next;
            red_reg     <= red_next;
            green_reg   <= green_next;
            blue_reg    <= blue_next;
        end
    end

    // end byte leaves the percents untouched, so the current values are the result
    assign res.hit        = hit;
    assign res.red_duty   = duty_of(red_reg);
    assign res.green_duty = duty_of(green_reg);
    assign res.blue_duty  = duty_of(blue_reg);

endmodule

// ===== src/rgb_command_frame_parser_core.sv =====
// Top level of the RGB command frame parser: input register, configuration
// registers, parser and result register. Depends on rgbcfp_pkg, rgbcfp_if, rgbcfp_parser.
//
//  channel | role   | payload                               | item
//  rx      | sink   | rx_byte                               | one received byte
//  duty    | source | red_duty, green_duty, blue_duty       | one set of duties per good frame
//  cfg     | sink   | index, data                           | one register write
//
// One byte per cycle sustained while the duty channel takes results; a taken byte is
// held in the input register and parsed from there, and a result goes to the result register.
// The parse state update in rgbcfp_parser is the loop that sets this rate.
// Reset puts the parser hunting for the start byte and loads register defaults.
// A stalled result holds the parser; the input register then fills and rx drops ready.
module rgb_command_frame_parser_core (
    input  logic    clk,
    input  logic    rst_n,
    rgbcfp_byte_if.sink   rx,
    rgbcfp_duty_if.source duty,
    rgbcfp_cfg_if.sink    cfg
);
    import rgbcfp_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic [DUTY_W-1:0] red_reg;
    logic [DUTY_W-1:0] green_reg;
    logic [DUTY_W-1:0] blue_reg;

    logic    out_free;
    logic    step;
    logic    rx_take;
    result_t res;

    assign out_free = !out_valid_reg || duty.ready;
    assign step     = in_valid_reg && out_free;
    assign rx.ready = !in_valid_reg || out_free;
    assign rx_take  = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_body_length <= RST_MAX_BODY_LENGTH;
            cfg_reg.start_char      <= RST_START_CHAR;
            cfg_reg.end_char        <= RST_END_CHAR;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_MAX_BODY_LENGTH: cfg_reg.max_body_length <= cfg.data;
                REG_START_CHAR:      cfg_reg.start_char      <= cfg.data;
                REG_END_CHAR:        cfg_reg.end_char        <= cfg.data;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rx_take)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;
            if (out_free)
                out_valid_reg <= step && res.hit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_take)
            in_byte_reg <= rx.rx_byte;
        if (out_free)
        begin
            red_reg   <= res.red_duty;
            green_reg <= res.green_duty;
            blue_reg  <= res.blue_duty;
        end
    end

    rgbcfp_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (in_byte_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    assign duty.valid      = out_valid_reg;
    assign duty.red_duty   = red_reg;
    assign duty.green_duty = green_reg;
    assign duty.blue_duty  = blue_reg;

endmodule

// ===== src/rgbcfp_checker.sv =====
// Port-level checks for rgb_command_frame_parser_core, bound to the top level.
// Depends on rgbcfp_pkg and rgb_command_frame_parser_core_defines.svh.
`include "rgb_command_frame_parser_core_defines.svh"

module rgbcfp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rx_valid,
    input logic                          rx_ready,
    input logic                          duty_valid,
    input logic                          duty_ready,
    input logic [rgbcfp_pkg::DUTY_W-1:0] red_duty,
    input logic [rgbcfp_pkg::DUTY_W-1:0] green_duty,
    input logic [rgbcfp_pkg::DUTY_W-1:0] blue_duty
);
    import rgbcfp_pkg::*;

    // a stalled result keeps its values
    `RGBCFP_ASSERT(a_duty_hold, clk, rst_n, duty_valid && !duty_ready |=> duty_valid && $stable(red_duty) && $stable(green_duty) && $stable(blue_duty), "duty item changed while stalled")

    // the only reason to refuse a byte is a result waiting downstream
    `RGBCFP_ASSERT_ALWAYS(a_rx_stall_cause, clk, !rx_ready |-> duty_valid && !duty_ready, "rx stalled without output back-pressure")

    // a fresh result comes from a taken byte that passed through the input register
    `RGBCFP_ASSERT(a_result_latency, clk, rst_n, $rose(duty_valid) |-> $past(rx_valid && rx_ready, 2), "result without matching byte")

endmodule

bind rgb_command_frame_parser_core rgbcfp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .rx_valid   (rx.valid),
    .rx_ready   (rx.ready),
    .duty_valid (duty.valid),
    .duty_ready (duty.ready),
    .red_duty   (duty.red_duty),
    .green_duty (duty.green_duty),
    .blue_duty  (duty.blue_duty)
);
